// ===== design/deq_pkg.sv =====
package deq_pkg;

    localparam int VALUE_W  = 32;
    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 2;

    // Operation codes carried in the input tuser field.
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_PEEK       = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;     // latch the accepted item
        logic exec;     // update pointers, write the store, issue the pop read
        logic grab;     // capture the popped entry, issue front and back reads
        logic load;     // load the output register
    } t_deq_cmd;

endpackage

// ===== design/deq_ram.sv =====
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    output logic [WIDTH-1:0]         o_rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== design/deq_ctrl.sv =====
module deq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output deq_pkg::t_deq_cmd o_cmd
);
    import deq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   in_accept;
    logic   out_free;

    // No item is taken while reset is held.
    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd      = '0;
        o_cmd.take = in_accept;
        o_cmd.exec = (r_state == S_EXEC);
        o_cmd.grab = (r_state == S_READ);
        o_cmd.load = (r_state == S_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: r_state <= S_READ;
                S_READ: r_state <= S_DONE;
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (o_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    // A finished result must wait while the previous one is still unclaimed.
    a_hold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result loaded over an unclaimed output");

    // A new result only appears as the sequence for an item completes.
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("output valid raised outside the completion step");

endmodule

// ===== design/deq_datapath.sv =====
module deq_datapath #(
    parameter int DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  deq_pkg::t_deq_cmd                i_cmd,
    input  logic [deq_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [deq_pkg::VALUE_W-1:0]      i_value,
    output logic [deq_pkg::VALUE_W-1:0]      o_popped_value,
    output logic [deq_pkg::STATUS_W-1:0]     o_status,
    output logic [deq_pkg::VALUE_W-1:0]      o_front_value,
    output logic [deq_pkg::VALUE_W-1:0]      o_back_value,
    output logic [$clog2(DEPTH+1)-1:0]       o_entry_count
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [OPCODE_W-1:0] r_opcode;
    logic [VALUE_W-1:0]  r_value;
    logic [AW-1:0]       r_head;
    logic [CW-1:0]       r_count;
    logic [STATUS_W-1:0] r_status;
    logic [VALUE_W-1:0]  r_popped;

    logic [AW-1:0]       n_head;
    logic [CW-1:0]       n_count;
    logic [STATUS_W-1:0] n_status;

    logic [VALUE_W-1:0]  r_out_popped;
    logic [STATUS_W-1:0] r_out_status;
    logic [VALUE_W-1:0]  r_out_front;
    logic [VALUE_W-1:0]  r_out_back;
    logic [CW-1:0]       r_out_count;

    logic [SW-1:0]       tail_sum;
    logic [AW-1:0]       tail_pos;
    logic [AW-1:0]       back_pos;
    logic [AW-1:0]       head_dec;
    logic                is_full;
    logic                is_empty;
    logic                we;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr_a;
    logic [VALUE_W-1:0]  rd_data_a;
    logic [VALUE_W-1:0]  rd_data_b;
    logic                pop_ok;

    // The slot just past the back; head + count stays below twice the depth.
    assign tail_sum = {1'b0, r_head} + SW'(r_count);
    assign tail_pos = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
    assign back_pos = (tail_pos == '0) ? LAST_IDX : AW'(tail_pos - 1'b1);
    assign head_dec = (r_head == '0) ? LAST_IDX : AW'(r_head - 1'b1);
    assign is_full  = (r_count == FULL_CNT);
    assign is_empty = (r_count == '0);

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_OK;
        we       = 1'b0;
        wr_addr  = tail_pos;
        unique case (r_opcode)
            OP_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_head  = head_dec;
                    n_count = CW'(r_count + 1'b1);
                    we      = i_cmd.exec;
                    wr_addr = head_dec;
                end
            end
            OP_PUSH_BACK: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = CW'(r_count + 1'b1);
                    we      = i_cmd.exec;
                end
            end
            OP_POP_FRONT: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head  = (r_head == LAST_IDX) ? '0 : AW'(r_head + 1'b1);
                    n_count = CW'(r_count - 1'b1);
                end
            end
            OP_POP_BACK: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = CW'(r_count - 1'b1);
                end
            end
            OP_CLEAR: begin
                n_head  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // During execution port A fetches the entry a pop removes; afterwards it
    // fetches the new front while port B fetches the new back.
    assign rd_addr_a = (i_cmd.exec && r_opcode == OP_POP_BACK) ? back_pos : r_head;

    assign pop_ok = (r_status == ST_OK)
                 && (r_opcode == OP_POP_FRONT || r_opcode == OP_POP_BACK);

    deq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_we        (we),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (r_value),
        .i_rd_addr_a (rd_addr_a),
        .o_rd_data_a (rd_data_a),
        .i_rd_addr_b (back_pos),
        .o_rd_data_b (rd_data_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_opcode <= i_opcode;
            r_value  <= i_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
        if (i_cmd.grab) begin
            r_popped <= pop_ok ? rd_data_a : '0;
        end
        if (i_cmd.load) begin
            r_out_popped <= r_popped;
            r_out_status <= r_status;
            r_out_front  <= is_empty ? '0 : rd_data_a;
            r_out_back   <= is_empty ? '0 : rd_data_b;
            r_out_count  <= r_count;
        end
    end

    assign o_popped_value = r_out_popped;
    assign o_status       = r_out_status;
    assign o_front_value  = r_out_front;
    assign o_back_value   = r_out_back;
    assign o_entry_count  = r_out_count;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= FULL_CNT) && (r_head <= LAST_IDX))
        else $error("queue pointers out of range");

    // The count moves by at most one per item, except for a clear.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_opcode != OP_CLEAR) |=>
            (r_count == $past(r_count) || r_count == CW'($past(r_count) + 1'b1)
             || r_count == CW'($past(r_count) - 1'b1)))
        else $error("entry count jumped");

endmodule

// ===== design/double_ended_queue.sv =====
// An item passes the execute, read and done steps; done loads the output register.
// No new item is taken before the last is done; the store's registered read is used
// twice in sequence per item, once for the popped entry and once for the new front
// and back. A waiting result holds the done step and so the next item. Reset
// (synchronous, active low) empties the queue; store contents are not cleared.
module double_ended_queue #(
    parameter int DEPTH = 1024
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_s_axis_tvalid,
    output logic                                           o_s_axis_tready,
    // value [31:0]
    input  logic [deq_pkg::VALUE_W-1:0]                    i_s_axis_tdata,
    // opcode [2:0]
    input  logic [deq_pkg::OPCODE_W-1:0]                   i_s_axis_tuser,
    output logic                                           o_m_axis_tvalid,
    input  logic                                           i_m_axis_tready,
    // popped_value, status, front_value, back_value, entry_count, then zero fill
    output logic [((3*32+2+$clog2(DEPTH+1)+7)/8)*8-1:0]    o_m_axis_tdata
);
    import deq_pkg::*;

    localparam int CW      = $clog2(DEPTH + 1);
    localparam int PACK_W  = 3 * VALUE_W + STATUS_W + CW;
    localparam int OUT_W   = ((3 * 32 + 2 + CW + 7) / 8) * 8;

    t_deq_cmd            cmd;
    logic [VALUE_W-1:0]  popped_value;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  front_value;
    logic [VALUE_W-1:0]  back_value;
    logic [CW-1:0]       entry_count;
    logic [PACK_W-1:0]   packed_out;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_opcode       (i_s_axis_tuser),
        .i_value        (i_s_axis_tdata),
        .o_popped_value (popped_value),
        .o_status       (status),
        .o_front_value  (front_value),
        .o_back_value   (back_value),
        .o_entry_count  (entry_count)
    );

    assign packed_out     = {entry_count, back_value, front_value, status, popped_value};
    assign o_m_axis_tdata = OUT_W'(packed_out);

endmodule

// ===== tb/deque_result_checker.sv =====
module deque_result_checker #(
    parameter int DEPTH = 1024
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_s_tvalid,
    input  logic                                          i_s_tready,
    // value [31:0]
    input  logic [deq_pkg::VALUE_W-1:0]                   i_s_tdata,
    // opcode [2:0]
    input  logic [deq_pkg::OPCODE_W-1:0]                  i_s_tuser,
    input  logic                                          i_m_tvalid,
    input  logic                                          i_m_tready,
    // popped_value, status, front_value, back_value, entry_count, then zero fill
    input  logic [((3*32+2+$clog2(DEPTH+1)+7)/8)*8-1:0]   i_m_tdata,
    output int                                            o_errors,
    output int                                            o_pending
);
    import deq_pkg::*;

    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = ((3*32 + 2 + CNT_W + 7) / 8) * 8;
    localparam int ST_LO   = VALUE_W;
    localparam int FRT_LO  = ST_LO + STATUS_W;
    localparam int BCK_LO  = FRT_LO + VALUE_W;
    localparam int CNT_LO  = BCK_LO + VALUE_W;
    localparam int PAD_LO  = CNT_LO + CNT_W;

    typedef struct packed {
        logic [VALUE_W-1:0]  popped;
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  front;
        logic [VALUE_W-1:0]  back;
        logic [CNT_W-1:0]    count;
    } t_deq_result;

    logic [VALUE_W-1:0] model_store [DEPTH];
    int                 head_idx;
    int                 entry_cnt;
    int                 error_cnt = 0;
    t_deq_result        results_due [$];

    task automatic log_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_cnt++;
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] got,
                               input logic [VALUE_W-1:0] want);
        if (got !== want) begin
            log_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    // Applies one operation to the mirror of the queue and returns the result it gives.
    task automatic predict_deque_op(input logic [OPCODE_W-1:0] op,
                                    input logic [VALUE_W-1:0] val,
                                    output t_deq_result res);
        res = '0;
        res.status = ST_OK;
        case (op)
            OP_PUSH_FRONT: begin
                if (entry_cnt >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    head_idx = (head_idx + DEPTH - 1) % DEPTH;
                    model_store[head_idx] = val;
                    entry_cnt++;
                end
            end
            OP_PUSH_BACK: begin
                if (entry_cnt >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    model_store[(head_idx + entry_cnt) % DEPTH] = val;
                    entry_cnt++;
                end
            end
            OP_POP_FRONT: begin
                if (entry_cnt == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.popped = model_store[head_idx];
                    head_idx = (head_idx + 1) % DEPTH;
                    entry_cnt--;
                end
            end
            OP_POP_BACK: begin
                if (entry_cnt == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.popped = model_store[(head_idx + entry_cnt - 1) % DEPTH];
                    entry_cnt--;
                end
            end
            OP_CLEAR: begin
                head_idx = 0;
                entry_cnt = 0;
            end
            default: begin
                // Peek and the two unused codes leave the queue alone.
            end
        endcase
        if (entry_cnt != 0) begin
            res.front = model_store[head_idx];
            res.back  = model_store[(head_idx + entry_cnt - 1) % DEPTH];
        end
        res.count = CNT_W'(entry_cnt);
    endtask

    always @(posedge i_clk) begin
        t_deq_result want;
        t_deq_result fresh;
        if (!i_rst_n) begin
            head_idx = 0;
            entry_cnt = 0;
            results_due.delete();
        end else begin
            // The result side is handled first so that an item accepted at this edge
            // can never be matched against a result leaving at the same edge.
            if (i_m_tvalid && i_m_tready) begin
                if (results_due.size() == 0) begin
                    log_mismatch($sformatf("result %h with none outstanding", i_m_tdata));
                end else begin
                    want = results_due[0];
                    results_due.delete(0);
                    check_field("popped_value", i_m_tdata[VALUE_W-1:0], want.popped);
                    check_field("status", VALUE_W'(i_m_tdata[FRT_LO-1:ST_LO]),
                                VALUE_W'(want.status));
                    check_field("front_value", i_m_tdata[BCK_LO-1:FRT_LO], want.front);
                    check_field("back_value", i_m_tdata[CNT_LO-1:BCK_LO], want.back);
                    check_field("entry_count", VALUE_W'(i_m_tdata[PAD_LO-1:CNT_LO]),
                                VALUE_W'(want.count));
                    check_field("zero fill", VALUE_W'(i_m_tdata[DATA_W-1:PAD_LO]), '0);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_deque_op(i_s_tuser, i_s_tdata, fresh);
                results_due = {results_due, fresh};
            end
        end
        o_errors  <= error_cnt;
        o_pending <= results_due.size();
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    import deq_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int DATA_W      = ((3*32 + 2 + $clog2(DEPTH + 1) + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 200000;

    // Codes outside the defined set; the block treats them as a peek.
    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [VALUE_W-1:0]  s_tdata = '0;
    logic [OPCODE_W-1:0] s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;

    int errors;
    int pending;
    int send_idle = 29;
    int recv_idle = 59;
    int cycle_cnt = 0;

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    deque_result_checker #(
        .DEPTH(DEPTH)
    ) u_result_check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(15))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // Valid stays high between back-to-back items and is only lowered for a gap.
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom();
            @(posedge clk);
            while ($urandom_range(99) < send_idle) begin
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
    endtask

    task automatic send_random(input int push_pct, input int pop_pct, input int clear_pct);
        int r;
        logic [OPCODE_W-1:0] op;
        r = $urandom_range(99);
        if (r < push_pct) begin
            op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end else if (r < push_pct + pop_pct) begin
            op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
        end else if (r < push_pct + pop_pct + clear_pct) begin
            op = OP_CLEAR;
        end else begin
            op = OPCODE_W'($urandom_range(int'(OP_PEEK), int'(OP_SPARE_HI)));
        end
        send_item(op, pick_value());
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Empty queue: pops fail, peeks and spare codes report zeros.
        send_item(OP_POP_FRONT, 32'h1234_5678);
        send_item(OP_POP_BACK, 32'hffff_ffff);
        send_item(OP_PEEK, 32'h8000_0000);
        send_item(OP_SPARE_LO, 32'h7fff_ffff);
        send_item(OP_SPARE_HI, 32'h5555_5555);
        send_item(OP_PUSH_BACK, 32'h7fff_ffff);
        send_item(OP_PUSH_FRONT, 32'h8000_0000);
        send_item(OP_PUSH_BACK, 32'h0000_0000);
        send_item(OP_PUSH_FRONT, 32'hffff_ffff);
        send_item(OP_PEEK, 32'haaaa_aaaa);
        send_item(OP_POP_BACK, 32'h0);
        send_item(OP_POP_FRONT, 32'h0);
        send_item(OP_POP_FRONT, 32'h0);
        send_item(OP_POP_BACK, 32'h0);
        send_item(OP_POP_BACK, 32'h0);
        send_item(OP_PUSH_BACK, 32'h5555_5555);
        send_item(OP_PUSH_FRONT, 32'haaaa_aaaa);
        send_item(OP_CLEAR, 32'hdead_beef);
        send_item(OP_PEEK, 32'h0);
        send_item(OP_PUSH_FRONT, 32'h0000_0001);
        send_item(OP_POP_BACK, 32'h0);

        repeat (60) send_random(55, 38, 1);
        send_idle = 59;
        recv_idle = 29;

        // Fill the queue to the brim under the second idling pattern.
        send_item(OP_CLEAR, pick_value());
        repeat (DEPTH) send_random(100, 0, 0);
        send_idle = 0;
        recv_idle = 0;

        // Keep pushing and popping around full, then work a small queue.
        repeat (20) send_random(70, 0, 0);
        repeat (40) send_random(50, 48, 0);
        send_item(OP_CLEAR, pick_value());
        repeat (20) send_random(40, 50, 2);
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/deq_pkg.sv
design/deq_ram.sv
design/deq_ctrl.sv
design/deq_datapath.sv
design/double_ended_queue.sv
tb/deque_result_checker.sv
tb/tb.sv
